>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl of the cell classifier
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define DITC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define DITC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/ditc_pkg.sv
// shared constants, types and code functions of the cell classifier
`timescale 1ns / 1ps

package ditc_pkg;

  // default sizes
  localparam int MAX_WIDTH_DEF     = 1024;
  localparam int MAX_CELL_SIDE_DEF = 16;
  localparam int MAX_HEIGHT        = 1024;

  // configuration port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY_MODE = 3'd0,
    REG_INVERT_GRAY  = 3'd1,
    REG_CELL_WIDTH   = 3'd2,
    REG_CELL_HEIGHT  = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5
  } reg_idx_t;

  // register reset values
  localparam logic [1:0]  RST_DISPLAY_MODE = 2'd0;
  localparam logic        RST_INVERT_GRAY  = 1'b0;
  localparam logic [4:0]  RST_CELL_WIDTH   = 5'd1;
  localparam logic [4:0]  RST_CELL_HEIGHT  = 5'd2;
  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd1024;

  // display modes, modes two and three act as color
  localparam logic [1:0] MODE_BITMAP = 2'd0;
  localparam logic [1:0] MODE_GRAY   = 2'd1;

  // hue classes
  localparam logic [2:0] HUE_RED     = 3'd0;
  localparam logic [2:0] HUE_YELLOW  = 3'd1;
  localparam logic [2:0] HUE_GREEN   = 3'd2;
  localparam logic [2:0] HUE_CYAN    = 3'd3;
  localparam logic [2:0] HUE_BLUE    = 3'd4;
  localparam logic [2:0] HUE_MAGENTA = 3'd5;
  localparam logic [2:0] HUE_NONE    = 3'd6;

  // gray thresholds and limits
  localparam logic [7:0] GRAY_T1      = 8'd51;
  localparam logic [7:0] GRAY_T2      = 8'd102;
  localparam logic [7:0] GRAY_T3      = 8'd153;
  localparam logic [7:0] GRAY_T4      = 8'd204;
  localparam logic [7:0] GRAY_MAX     = 8'd255;
  localparam logic [9:0] HUE_MIN_SUM  = 10'd153;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RMW,
    ST_TK_RD,
    ST_TK_ACC,
    ST_BM_FIN,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_FIN
  } state_t;

  // gray value to level 0..4
  function automatic logic [3:0] gray_level(input logic [7:0] v);
    logic [3:0] lvl;
    if (v < GRAY_T1) lvl = 4'd0;
    else if (v < GRAY_T2) lvl = 4'd1;
    else if (v < GRAY_T3) lvl = 4'd2;
    else if (v < GRAY_T4) lvl = 4'd3;
    else lvl = 4'd4;
    return lvl;
  endfunction

  // hue class from averaged rgb by exact integer sector tests
  function automatic logic [2:0] hue_of(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    logic [9:0]         tot;
    logic [7:0]         mx;
    logic [7:0]         mn;
    logic [7:0]         dlt;
    logic [1:0]         bin;
    logic signed [11:0] sr;
    logic signed [11:0] sg;
    logic signed [11:0] sb;
    logic signed [11:0] dd;
    logic signed [11:0] t;
    logic signed [11:0] t2;
    logic [2:0]         h;
    tot = 10'(r) + 10'(g) + 10'(b);
    mx  = r;
    mn  = r;
    bin = 2'd0;
    if (mx < g) begin
      mx  = g;
      bin = 2'd1;
    end
    if (mx < b) begin
      mx  = b;
      bin = 2'd2;
    end
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dlt = mx - mn;
    sr  = signed'({4'b0, r});
    sg  = signed'({4'b0, g});
    sb  = signed'({4'b0, b});
    dd  = signed'({4'b0, dlt});
    t   = '0;
    t2  = '0;
    h   = HUE_NONE;
    if (tot < HUE_MIN_SUM || mx == 8'd0 || (10'(dlt) << 2) < 10'(mx)) begin
      h = HUE_NONE;
    end else if (bin == 2'd0) begin
      t  = sg - sb;
      t2 = t + t;
      if (t >= 0) h = (t2 < dd) ? HUE_RED : HUE_YELLOW;
      else h = (t2 < -dd) ? HUE_MAGENTA : HUE_RED;
    end else if (bin == 2'd1) begin
      t  = sb - sr;
      t2 = t + t;
      if (t2 < -dd) h = HUE_YELLOW;
      else if (t2 < dd) h = HUE_GREEN;
      else h = HUE_CYAN;
    end else begin
      t  = sr - sg;
      t2 = t + t;
      if (t2 < -dd) h = HUE_CYAN;
      else if (t2 < dd) h = HUE_BLUE;
      else h = HUE_MAGENTA;
    end
    return h;
  endfunction

endpackage

>>> rtl/core/ditc_pix_if.sv
// pixel input channel
`timescale 1ns / 1ps

interface ditc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

>>> rtl/core/ditc_code_if.sv
// cell code result channel
`timescale 1ns / 1ps

interface ditc_code_if;
  logic       valid;
  logic       ready;
  logic [9:0] cell_column;
  logic [9:0] cell_row;
  logic [3:0] glyph_code;
  logic [2:0] hue_class;
  logic       hue_changed;
  logic       row_end;

  modport source(output valid, cell_column, cell_row, glyph_code, hue_class, hue_changed,
                 row_end, input ready);
  modport sink(input valid, cell_column, cell_row, glyph_code, hue_class, hue_changed,
               row_end, output ready);
endinterface

>>> rtl/core/ditc_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps

interface ditc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ditc_pkg::CFG_IDX_W-1:0]  index;
  logic [ditc_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/ditc_col_store.sv
// line store of per-column rgb sums, one write and one registered read port
`timescale 1ns / 1ps

module ditc_col_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 36
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/ditc_div.sv
// restoring divider, one quotient bit per cycle, quotient known to fit QW bits
`timescale 1ns / 1ps

module ditc_div #(
  parameter int DVW = 16,
  parameter int DSW = 9,
  parameter int QW  = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [QW-1:0]  quotient
);

  localparam int DDW  = DSW + QW - 1;
  localparam int CW   = (DVW > DDW) ? DVW : DDW;
  localparam int CNTW = $clog2(QW + 1);

  logic [CW-1:0]   rem_r;
  logic [DDW-1:0]  den_r;
  logic [QW-1:0]   q_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic            ge;

  assign ge = rem_r >= CW'(den_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: compare, subtract, shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= CW'(dividend);
      den_r <= {divisor, {(QW - 1){1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - CW'(den_r);
      den_r <= den_r >> 1;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> rtl/core/image_to_text_cell_classifier_top.sv
// top level of the cell classifier: config registers, sequencer and datapath
//
// Usage: pixels enter in raster order on in_pix (red carries the gray sample in
// bitmap and gray modes). Each completed character cell yields one transfer on
// out_code; cells that run past the right or bottom edge yield none.
// Registers are written on cfg_wr (index 0..5); a write restarts the frame at
// the top left. cfg_wr and in_pix are both taken only while the sequencer is
// idle, and a pending register write takes priority over a pixel.
// Sequence: a pixel that closes no cell is accepted in idle, then goes through
// the line store read-modify-write, set by the registered line store port.
// A closing pixel then reads each column back through the accumulator, in a
// read state and an accumulate state per column (cell_width columns, or
// 2*cell_width in bitmap mode), and a finishing state; gray mode adds 1
// division, color mode 4 (three channel means and the gray mean), each on the
// shared 8-step divider.
// Reset: synchronous, active low; registers return to their defaults and the
// frame restarts. The line store needs no clearing: the first line of every
// cell row ignores old contents. A stalled receiver holds the output register,
// and the block keeps taking pixels until the next cell result is ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module image_to_text_cell_classifier_top #(
  parameter int MAX_WIDTH     = ditc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_CELL_SIDE = ditc_pkg::MAX_CELL_SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  ditc_pix_if.sink          in_pix,
  ditc_code_if.source       out_code,
  ditc_cfg_if.sink          cfg_wr
);

  localparam int XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int XW1  = $clog2(MAX_WIDTH + 1);
  localparam int CSW  = $clog2(MAX_CELL_SIDE + 1);
  localparam int SPW  = CSW + 1;
  localparam int SW   = $clog2(MAX_CELL_SIDE * 255 + 1);
  localparam int ACCW = $clog2(MAX_CELL_SIDE * MAX_CELL_SIDE * 255 + 1);
  localparam int AW   = $clog2(MAX_CELL_SIDE * MAX_CELL_SIDE + 1);
  localparam int THW  = AW + 7;
  localparam int TCW  = (ACCW > THW) ? ACCW : THW;
  localparam int EW   = $clog2(MAX_WIDTH + 2 * MAX_CELL_SIDE + 1);
  localparam int QD   = MAX_WIDTH / 2;
  localparam int QIW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int DVW  = (ACCW > 10) ? ACCW : 10;
  localparam int DSW  = (AW > 2) ? AW : 2;

  // configuration registers
  logic [1:0]  mode_r;
  logic        inv_r;
  logic [4:0]  cw_reg_r;
  logic [4:0]  ch_reg_r;
  logic [10:0] iw_reg_r;
  logic [10:0] ih_reg_r;

  // sequencer
  ditc_pkg::state_t state_r, state_nxt;

  // position
  logic [XW-1:0]  x_r, x_nxt;
  logic [9:0]     y_r, y_nxt;
  logic [CSW-1:0] lic_r, lic_nxt;
  logic [SPW-1:0] col_r, col_nxt;
  logic [XW-1:0]  cell_r, cell_nxt;
  logic [9:0]     crow_r, crow_nxt;
  logic [2:0]     prev_hue_r;

  // datapath registers
  logic [7:0]      pix_r [3];
  logic [XW-1:0]   addr_r;
  logic [CSW-1:0]  tcnt_r;
  logic            half_r;
  logic [ACCW-1:0] acc_r [3];
  logic            abit_r;
  logic            bbit_r;
  logic [1:0]      sel_r;
  logic [7:0]      s_r [4];
  logic            out_valid_r;
  logic [9:0]      out_col_r;
  logic [9:0]      out_row_r;
  logic [3:0]      out_glyph_r;
  logic [2:0]      out_hue_r;
  logic            out_chg_r;
  logic            out_end_r;
  logic [1:0]      qmem_r [2**QIW];
  logic [1:0]      q_rd_r;

  // derived sizes
  logic [CSW-1:0] cw_c;
  logic [CSW-1:0] ch_c;
  logic [XW1-1:0] w_c;
  logic [10:0]    h_c;
  logic           bitmap;
  logic           gray;
  logic [SPW-1:0] span;
  logic [AW-1:0]  area;
  logic [THW-1:0] thr;

  // control strobes
  logic in_acc;
  logic cfg_acc;
  logic cfg_hit;
  logic out_free;
  logic complete;
  logic take_last;
  logic adv;
  logic load_out;
  logic store_wr;
  logic div_start;
  logic div_done;
  logic bm_even;
  logic [XW-1:0] rd_addr;

  // datapath wires
  logic [3*SW-1:0] rd_data;
  logic [3*SW-1:0] wr_data;
  logic [SW-1:0]   wr_f [3];
  logic [ACCW-1:0] tsum [3];
  logic            tsum_ge;
  logic [DVW-1:0]  div_dividend;
  logic [DSW-1:0]  div_divisor;
  logic [7:0]      div_q;
  logic [7:0]      gv_raw;
  logic [7:0]      gv;
  logic [2:0]      hue_now;
  logic [2:0]      hue_prev;
  logic            row_last;
  logic [XW1-1:0]  x_inc;
  logic            line_end;
  logic            col_last;
  logic [CSW:0]    lic_inc;
  logic [10:0]     y_inc;

  assign in_acc  = in_pix.valid && in_pix.ready;
  assign cfg_acc = cfg_wr.valid && cfg_wr.ready;
  assign cfg_hit = cfg_acc && (cfg_wr.index <= ditc_pkg::REG_IMAGE_HEIGHT);

  // size clamping
  always_comb begin
    if (cw_reg_r == 5'd0) cw_c = CSW'(1);
    else if ({3'b0, cw_reg_r} > 8'(MAX_CELL_SIDE)) cw_c = CSW'(MAX_CELL_SIDE);
    else cw_c = CSW'(cw_reg_r);
    if (ch_reg_r == 5'd0) ch_c = CSW'(1);
    else if ({3'b0, ch_reg_r} > 8'(MAX_CELL_SIDE)) ch_c = CSW'(MAX_CELL_SIDE);
    else ch_c = CSW'(ch_reg_r);
    if (iw_reg_r == 11'd0) w_c = XW1'(1);
    else if ({2'b0, iw_reg_r} > 13'(MAX_WIDTH)) w_c = XW1'(MAX_WIDTH);
    else w_c = XW1'(iw_reg_r);
    if (ih_reg_r == 11'd0) h_c = 11'd1;
    else if (ih_reg_r > 11'(ditc_pkg::MAX_HEIGHT)) h_c = 11'(ditc_pkg::MAX_HEIGHT);
    else h_c = ih_reg_r;
  end

  assign bitmap = (mode_r == ditc_pkg::MODE_BITMAP);
  assign gray   = (mode_r == ditc_pkg::MODE_GRAY);
  assign span   = bitmap ? {cw_c, 1'b0} : {1'b0, cw_c};
  assign area   = AW'(cw_c) * AW'(ch_c);
  assign thr    = {area, 7'b0};

  // cell boundary tests
  assign col_last  = (col_r == span - 1'b1);
  assign lic_inc   = {1'b0, lic_r} + 1'b1;
  assign complete  = (lic_inc >= {1'b0, ch_c}) && col_last;
  assign take_last = ({1'b0, tcnt_r} + 1'b1) == {1'b0, cw_c};
  assign row_last  = (EW'(x_r) + EW'(1) + EW'(span)) > EW'(w_c);
  assign bm_even   = !crow_r[0];
  assign out_free  = !out_valid_r || out_code.ready;

  // position advance
  assign x_inc    = XW1'(x_r) + 1'b1;
  assign line_end = x_inc >= w_c;
  assign y_inc    = {1'b0, y_r} + 1'b1;

  always_comb begin
    x_nxt    = line_end ? '0 : XW'(x_inc);
    col_nxt  = (line_end || col_last) ? '0 : col_r + 1'b1;
    cell_nxt = line_end ? '0 : (col_last ? cell_r + 1'b1 : cell_r);
    lic_nxt  = lic_r;
    crow_nxt = crow_r;
    y_nxt    = y_r;
    if (line_end) begin
      if (lic_inc >= {1'b0, ch_c}) begin
        lic_nxt  = '0;
        crow_nxt = crow_r + 1'b1;
      end else begin
        lic_nxt = CSW'(lic_inc);
      end
      if (y_inc >= h_c) begin
        y_nxt    = '0;
        lic_nxt  = '0;
        crow_nxt = '0;
      end else begin
        y_nxt = 10'(y_inc);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ditc_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = ditc_pkg::ST_RMW;
      end
      ditc_pkg::ST_RMW: begin
        state_nxt = complete ? ditc_pkg::ST_TK_RD : ditc_pkg::ST_IDLE;
      end
      ditc_pkg::ST_TK_RD: begin
        state_nxt = ditc_pkg::ST_TK_ACC;
      end
      ditc_pkg::ST_TK_ACC: begin
        if (!take_last) state_nxt = ditc_pkg::ST_TK_RD;
        else if (!bitmap) state_nxt = ditc_pkg::ST_DIV_GO;
        else if (half_r) state_nxt = ditc_pkg::ST_BM_FIN;
        else state_nxt = ditc_pkg::ST_TK_RD;
      end
      ditc_pkg::ST_BM_FIN: begin
        if (bm_even || out_free) state_nxt = ditc_pkg::ST_IDLE;
      end
      ditc_pkg::ST_DIV_GO: begin
        state_nxt = ditc_pkg::ST_DIV_RUN;
      end
      ditc_pkg::ST_DIV_RUN: begin
        if (div_done) begin
          state_nxt = (gray || sel_r == 2'd3) ? ditc_pkg::ST_FIN : ditc_pkg::ST_DIV_GO;
        end
      end
      ditc_pkg::ST_FIN: begin
        if (out_free) state_nxt = ditc_pkg::ST_IDLE;
      end
      default: state_nxt = ditc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_pix.ready = 1'b0;
    cfg_wr.ready = 1'b0;
    store_wr     = 1'b0;
    div_start    = 1'b0;
    adv          = 1'b0;
    load_out     = 1'b0;
    rd_addr      = addr_r;
    unique case (state_r)
      ditc_pkg::ST_IDLE: begin
        cfg_wr.ready = 1'b1;
        in_pix.ready = !cfg_wr.valid;
        rd_addr      = x_r;
      end
      ditc_pkg::ST_RMW: begin
        store_wr = 1'b1;
        adv      = !complete;
      end
      ditc_pkg::ST_BM_FIN: begin
        if (bm_even) begin
          adv = 1'b1;
        end else if (out_free) begin
          adv      = 1'b1;
          load_out = 1'b1;
        end
      end
      ditc_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
      end
      ditc_pkg::ST_FIN: begin
        if (out_free) begin
          adv      = 1'b1;
          load_out = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // line store update and readback sums
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wr_f[k] = ((lic_r == '0) ? SW'(0) : rd_data[k*SW +: SW]) + SW'(pix_r[k]);
      tsum[k] = acc_r[k] + ACCW'(rd_data[k*SW +: SW]);
    end
  end
  assign wr_data = {wr_f[2], wr_f[1], wr_f[0]};
  assign tsum_ge = TCW'(tsum[0]) >= TCW'(thr);

  ditc_col_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (XW),
    .DW    (3 * SW)
  ) u_col_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (store_wr),
    .wr_addr (x_r),
    .wr_data (wr_data)
  );

  // divider operand select: channel means, then the gray mean of three
  always_comb begin
    case (sel_r)
      2'd0:    div_dividend = DVW'(acc_r[0]);
      2'd1:    div_dividend = DVW'(acc_r[1]);
      2'd2:    div_dividend = DVW'(acc_r[2]);
      default: div_dividend = DVW'(10'(s_r[0]) + 10'(s_r[1]) + 10'(s_r[2]));
    endcase
    div_divisor = (sel_r == 2'd3) ? DSW'(3) : DSW'(area);
  end

  ditc_div #(
    .DVW (DVW),
    .DSW (DSW),
    .QW  (8)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // gray value and hue of the finished cell
  assign gv_raw   = gray ? s_r[0] : s_r[3];
  assign gv       = inv_r ? (ditc_pkg::GRAY_MAX - gv_raw) : gv_raw;
  assign hue_now  = ditc_pkg::hue_of(s_r[0], s_r[1], s_r[2]);
  assign hue_prev = (cell_r == '0) ? ditc_pkg::HUE_NONE : prev_hue_r;

  // top quadrant bits of the even cell row
  always_ff @(posedge clk) begin
    if (state_r == ditc_pkg::ST_BM_FIN && bm_even) begin
      qmem_r[cell_r[QIW-1:0]] <= {bbit_r, abit_r};
    end
    q_rd_r <= qmem_r[cell_r[QIW-1:0]];
  end

  // state, configuration and position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ditc_pkg::ST_IDLE;
      mode_r     <= ditc_pkg::RST_DISPLAY_MODE;
      inv_r      <= ditc_pkg::RST_INVERT_GRAY;
      cw_reg_r   <= ditc_pkg::RST_CELL_WIDTH;
      ch_reg_r   <= ditc_pkg::RST_CELL_HEIGHT;
      iw_reg_r   <= ditc_pkg::RST_IMAGE_WIDTH;
      ih_reg_r   <= ditc_pkg::RST_IMAGE_HEIGHT;
      x_r        <= '0;
      y_r        <= '0;
      lic_r      <= '0;
      col_r      <= '0;
      cell_r     <= '0;
      crow_r     <= '0;
      prev_hue_r <= ditc_pkg::HUE_NONE;
    end else if (cfg_hit) begin
      unique case (cfg_wr.index)
        ditc_pkg::REG_DISPLAY_MODE: mode_r   <= cfg_wr.data[1:0];
        ditc_pkg::REG_INVERT_GRAY:  inv_r    <= cfg_wr.data[0];
        ditc_pkg::REG_CELL_WIDTH:   cw_reg_r <= cfg_wr.data[4:0];
        ditc_pkg::REG_CELL_HEIGHT:  ch_reg_r <= cfg_wr.data[4:0];
        ditc_pkg::REG_IMAGE_WIDTH:  iw_reg_r <= cfg_wr.data;
        default:                    ih_reg_r <= cfg_wr.data;
      endcase
      state_r    <= ditc_pkg::ST_IDLE;
      x_r        <= '0;
      y_r        <= '0;
      lic_r      <= '0;
      col_r      <= '0;
      cell_r     <= '0;
      crow_r     <= '0;
      prev_hue_r <= ditc_pkg::HUE_NONE;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        x_r    <= x_nxt;
        y_r    <= y_nxt;
        lic_r  <= lic_nxt;
        col_r  <= col_nxt;
        cell_r <= cell_nxt;
        crow_r <= crow_nxt;
      end
      if (state_r == ditc_pkg::ST_FIN && out_free && !bitmap && !gray) begin
        prev_hue_r <= hue_now;
      end
    end
  end

  // take and divide datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r[0] <= in_pix.red;
      pix_r[1] <= in_pix.green;
      pix_r[2] <= in_pix.blue;
    end
    case (state_r)
      ditc_pkg::ST_RMW: begin
        addr_r <= XW'(x_inc - XW1'(span));
        tcnt_r <= '0;
        half_r <= 1'b0;
        sel_r  <= 2'd0;
        for (int k = 0; k < 3; k++) acc_r[k] <= '0;
      end
      ditc_pkg::ST_TK_ACC: begin
        addr_r <= addr_r + 1'b1;
        if (take_last) begin
          tcnt_r <= '0;
          if (bitmap && !half_r) begin
            abit_r <= tsum_ge;
            half_r <= 1'b1;
            for (int k = 0; k < 3; k++) acc_r[k] <= '0;
          end else if (bitmap) begin
            bbit_r <= tsum_ge;
          end else begin
            for (int k = 0; k < 3; k++) acc_r[k] <= tsum[k];
          end
        end else begin
          tcnt_r <= tcnt_r + 1'b1;
          for (int k = 0; k < 3; k++) acc_r[k] <= tsum[k];
        end
      end
      ditc_pkg::ST_DIV_RUN: begin
        if (div_done) begin
          s_r[sel_r] <= div_q;
          sel_r      <= sel_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_code.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_col_r <= 10'(cell_r);
      out_end_r <= row_last;
      if (state_r == ditc_pkg::ST_BM_FIN) begin
        out_row_r   <= crow_r >> 1;
        out_glyph_r <= {bbit_r, abit_r, q_rd_r} ^ (inv_r ? 4'hF : 4'h0);
        out_hue_r   <= ditc_pkg::HUE_NONE;
        out_chg_r   <= 1'b0;
      end else begin
        out_row_r   <= crow_r;
        out_glyph_r <= ditc_pkg::gray_level(gv);
        if (gray) begin
          out_hue_r <= ditc_pkg::HUE_NONE;
          out_chg_r <= 1'b0;
        end else begin
          out_hue_r <= hue_now;
          out_chg_r <= (hue_now != hue_prev);
        end
      end
    end
  end

  assign out_code.valid       = out_valid_r;
  assign out_code.cell_column = out_col_r;
  assign out_code.cell_row    = out_row_r;
  assign out_code.glyph_code  = out_glyph_r;
  assign out_code.hue_class   = out_hue_r;
  assign out_code.hue_changed = out_chg_r;
  assign out_code.row_end     = out_end_r;

  // checks
  `DITC_ASSERT_RST(a_rst_out_empty, !rst_n |=> !out_valid_r, "output valid after reset")
  `DITC_ASSERT(a_accept_to_rmw, in_acc |=> state_r == ditc_pkg::ST_RMW, "accept did not start rmw")
  `DITC_ASSERT(a_x_in_line, (state_r == ditc_pkg::ST_IDLE) |-> (XW1'(x_r) < w_c), "x past line")
  `DITC_ASSERT(a_div_done_run, div_done |-> (state_r == ditc_pkg::ST_DIV_RUN), "stray divide done")

endmodule
